>>> hw/rtl/three_point_vector_angle_core_macros.svh
// Assertion macros used by the angle core top level.
`ifndef THREE_POINT_VECTOR_ANGLE_CORE_MACROS_SVH
`define THREE_POINT_VECTOR_ANGLE_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define TVAC_ASSERT_NOW(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tvac assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define TVAC_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tvac assertion failed");

`endif

>>> hw/rtl/tvac_pkg.sv
// Shared constants, types and the arctangent step table of the angle core.
`default_nettype none
package tvac_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int NORM_BITS      = 30;
	localparam int ROOT_W         = 62;
	localparam int SQRT_STEPS     = 31;
	localparam int CORDIC_STEPS   = 24;
	localparam int XY_W           = 34;
	localparam int Z_W            = 32;
	localparam int ANGLE_W        = 15;
	localparam int UNIT_SHIFT     = 16;

	localparam logic signed [Z_W-1:0] Z_RIGHT    = Z_W'(589824000);
	localparam logic signed [Z_W-1:0] Z_STRAIGHT = Z_W'(1179648000);
	localparam logic signed [Z_W-1:0] Z_HALF_LSB = Z_W'(32768);

	// Control that travels with each transaction through the pipeline.
	typedef struct packed {
		logic vld;
		logic obtuse;
		logic degen;
	} side_t;

	// atan(2^-i) in units of 1/65536 centidegree, rounded to nearest.
	function automatic logic signed [Z_W-1:0] atan_unit(input int i);
		logic signed [Z_W-1:0] r;
		case (i)
			0: r = Z_W'(294912000);
			1: r = Z_W'(174096719);
			2: r = Z_W'(91987925);
			3: r = Z_W'(46694507);
			4: r = Z_W'(23437865);
			5: r = Z_W'(11730358);
			6: r = Z_W'(5866610);
			7: r = Z_W'(2933484);
			8: r = Z_W'(1466764);
			9: r = Z_W'(733385);
			10: r = Z_W'(366693);
			11: r = Z_W'(183346);
			12: r = Z_W'(91673);
			13: r = Z_W'(45837);
			14: r = Z_W'(22918);
			15: r = Z_W'(11459);
			16: r = Z_W'(5730);
			17: r = Z_W'(2865);
			18: r = Z_W'(1432);
			19: r = Z_W'(716);
			20: r = Z_W'(358);
			21: r = Z_W'(179);
			22: r = Z_W'(90);
			23: r = Z_W'(45);
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

>>> hw/rtl/tvac_sqrt_cell.sv
// One digit step of the integer square root chain.
`default_nettype none
module tvac_sqrt_cell #(
	parameter int IDX = 0
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               en,
	input  wire tvac_pkg::side_t                    side_i,
	input  wire logic [tvac_pkg::ROOT_W-1:0]        n_i,
	input  wire logic [tvac_pkg::ROOT_W-1:0]        res_i,
	input  wire logic [tvac_pkg::NORM_BITS-1:0]     x_i,
	output tvac_pkg::side_t                         side_o,
	output logic [tvac_pkg::ROOT_W-1:0]             n_o,
	output logic [tvac_pkg::ROOT_W-1:0]             res_o,
	output logic [tvac_pkg::NORM_BITS-1:0]          x_o
);

	localparam logic [tvac_pkg::ROOT_W:0] BIT =
		(tvac_pkg::ROOT_W+1)'(1) << (tvac_pkg::ROOT_W - 2 - 2 * IDX);

	logic [tvac_pkg::ROOT_W:0]   trial;
	logic                        take;
	logic [tvac_pkg::ROOT_W-1:0] n_nxt;
	logic [tvac_pkg::ROOT_W-1:0] res_nxt;
	tvac_pkg::side_t             side_q;
	logic [tvac_pkg::ROOT_W-1:0] n_q;
	logic [tvac_pkg::ROOT_W-1:0] res_q;
	logic [tvac_pkg::NORM_BITS-1:0] x_q;

	// Try to subtract the candidate root digit from the remainder.
	always_comb begin
		trial = {1'b0, res_i} + BIT;
		take  = ({1'b0, n_i} >= trial);
		if (take) begin
			n_nxt   = n_i - trial[tvac_pkg::ROOT_W-1:0];
			res_nxt = (res_i >> 1) + BIT[tvac_pkg::ROOT_W-1:0];
		end else begin
			n_nxt   = n_i;
			res_nxt = res_i >> 1;
		end
	end

	// Transaction control moves on with the pipeline enable.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= '0;
		end else if (en) begin
			side_q <= side_i;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (en) begin
			n_q   <= n_nxt;
			res_q <= res_nxt;
			x_q   <= x_i;
		end
	end

	assign side_o = side_q;
	assign n_o    = n_q;
	assign res_o  = res_q;
	assign x_o    = x_q;

endmodule
`default_nettype wire

>>> hw/rtl/tvac_cordic_cell.sv
// One vectoring rotation of the arctangent chain.
`default_nettype none
module tvac_cordic_cell #(
	parameter int IDX = 0
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               en,
	input  wire tvac_pkg::side_t                    side_i,
	input  wire logic signed [tvac_pkg::XY_W-1:0]   x_i,
	input  wire logic signed [tvac_pkg::XY_W-1:0]   y_i,
	input  wire logic signed [tvac_pkg::Z_W-1:0]    z_i,
	output tvac_pkg::side_t                         side_o,
	output logic signed [tvac_pkg::XY_W-1:0]        x_o,
	output logic signed [tvac_pkg::XY_W-1:0]        y_o,
	output logic signed [tvac_pkg::Z_W-1:0]         z_o
);

	localparam logic signed [tvac_pkg::Z_W-1:0] STEP = tvac_pkg::atan_unit(IDX);

	logic signed [tvac_pkg::XY_W-1:0] xs;
	logic signed [tvac_pkg::XY_W-1:0] ys;
	logic signed [tvac_pkg::XY_W-1:0] x_nxt;
	logic signed [tvac_pkg::XY_W-1:0] y_nxt;
	logic signed [tvac_pkg::Z_W-1:0]  z_nxt;
	tvac_pkg::side_t                  side_q;
	logic signed [tvac_pkg::XY_W-1:0] x_q;
	logic signed [tvac_pkg::XY_W-1:0] y_q;
	logic signed [tvac_pkg::Z_W-1:0]  z_q;

	// Rotate toward the x axis; the sign of y picks the direction.
	always_comb begin
		xs = x_i >>> IDX;
		ys = y_i >>> IDX;
		if (!y_i[tvac_pkg::XY_W-1]) begin
			x_nxt = x_i + ys;
			y_nxt = y_i - xs;
			z_nxt = z_i + STEP;
		end else begin
			x_nxt = x_i - ys;
			y_nxt = y_i + xs;
			z_nxt = z_i - STEP;
		end
	end

	// Transaction control moves on with the pipeline enable.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= '0;
		end else if (en) begin
			side_q <= side_i;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (en) begin
			x_q <= x_nxt;
			y_q <= y_nxt;
			z_q <= z_nxt;
		end
	end

	assign side_o = side_q;
	assign x_o    = x_q;
	assign y_o    = y_q;
	assign z_o    = z_q;

endmodule
`default_nettype wire

>>> hw/rtl/three_point_vector_angle_core.sv
// Top level of the three-point vector angle core.
//
//  channel | direction | handshake            | payload
//  in      | into core | in_valid / in_stall   | first_*, middle_*, last_* coordinates
//  out     | from core | out_valid / out_stall | angle_centideg, degenerate
//
// One transaction is accepted per cycle while in_stall is low; each result passes through
// 9 front stages, 31 square root cells, 24 rotation cells and one output register.
// The whole pipeline advances together; it halts only while a result waits under out_stall.
// Reset clears the valid bits; no clearing pass is needed.
`default_nettype none
`include "three_point_vector_angle_core_macros.svh"
module three_point_vector_angle_core #(
	parameter int COORD_BITS = tvac_pkg::COORD_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic signed [COORD_BITS-1:0]  first_x,
	input  wire logic signed [COORD_BITS-1:0]  first_y,
	input  wire logic signed [COORD_BITS-1:0]  first_z,
	input  wire logic signed [COORD_BITS-1:0]  middle_x,
	input  wire logic signed [COORD_BITS-1:0]  middle_y,
	input  wire logic signed [COORD_BITS-1:0]  middle_z,
	input  wire logic signed [COORD_BITS-1:0]  last_x,
	input  wire logic signed [COORD_BITS-1:0]  last_y,
	input  wire logic signed [COORD_BITS-1:0]  last_z,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [tvac_pkg::ANGLE_W-1:0]       angle_centideg,
	output logic                               degenerate
);

	localparam int DW   = COORD_BITS + 1;
	localparam int PW   = 2 * DW + 2;
	localparam int NB   = tvac_pkg::NORM_BITS;
	localparam int NW   = PW + NB;
	localparam int SW   = $clog2(NW + 1);
	localparam int RW   = tvac_pkg::ROOT_W;
	localparam int SQN  = tvac_pkg::SQRT_STEPS;
	localparam int CRN  = tvac_pkg::CORDIC_STEPS;
	localparam int XW   = tvac_pkg::XY_W;
	localparam int ZW   = tvac_pkg::Z_W;
	localparam int AW   = tvac_pkg::ANGLE_W;

	logic en;

	tvac_pkg::side_t side_s1, side_s2, side_s3, side_s4, side_s5;
	tvac_pkg::side_t side_s6, side_s7, side_s8, side_s9;

	logic signed [DW-1:0]   ux_s1, uy_s1, uz_s1, vx_s1, vy_s1, vz_s1;
	logic signed [2*DW-1:0] pdx_s2, pdy_s2, pdz_s2;
	logic signed [2*DW-1:0] pc1_s2, pc2_s2, pc3_s2, pc4_s2, pc5_s2, pc6_s2;
	logic signed [PW-1:0]   dot_s3, wx_s3, wy_s3, wz_s3;
	logic [PW-1:0]          mg_s4 [4];
	logic [PW-1:0]          mg_s5 [4];
	logic [PW-1:0]          mx_s5;
	logic [PW-1:0]          mg_s6 [4];
	logic [SW-1:0]          rs_s6, ls_s6;
	logic [NB-1:0]          nm_s7 [4];
	logic [NB-1:0]          md_s8;
	logic [2*NB-1:0]        sq1_s8, sq2_s8, sq3_s8;
	logic [NB-1:0]          md_s9;
	logic [RW-1:0]          ysq_s9;

	logic [PW-1:0]          mg_c [4];
	logic [PW-1:0]          mx_c;
	logic [SW-1:0]          pos_c;
	logic [SW-1:0]          rs_c, ls_c;
	logic [NW-1:0]          ext_c [4];

	tvac_pkg::side_t        sq_side [SQN+1];
	logic [RW-1:0]          sq_n    [SQN+1];
	logic [RW-1:0]          sq_res  [SQN+1];
	logic [NB-1:0]          sq_x    [SQN+1];

	tvac_pkg::side_t        cr_side [CRN+1];
	logic signed [XW-1:0]   cr_x    [CRN+1];
	logic signed [XW-1:0]   cr_y    [CRN+1];
	logic signed [ZW-1:0]   cr_z    [CRN+1];

	logic signed [ZW-1:0]   zc_c, ang_c, rnd_c;
	logic                   out_valid_q, degenerate_q;
	logic [AW-1:0]          angle_q;

	// The pipeline advances unless a finished result is held back.
	assign en       = !(out_valid_q && out_stall);
	assign in_stall = !en;

	// Magnitudes of the signed sums and their maximum.
	always_comb begin
		mg_c[0] = dot_s3[PW-1] ? PW'(-dot_s3) : PW'(dot_s3);
		mg_c[1] = wx_s3[PW-1]  ? PW'(-wx_s3)  : PW'(wx_s3);
		mg_c[2] = wy_s3[PW-1]  ? PW'(-wy_s3)  : PW'(wy_s3);
		mg_c[3] = wz_s3[PW-1]  ? PW'(-wz_s3)  : PW'(wz_s3);
		mx_c = mg_s4[0];
		for (int k = 1; k < 4; k++) begin
			if (mg_s4[k] > mx_c) begin
				mx_c = mg_s4[k];
			end
		end
	end

	// Leading one of the maximum sets the common normalizing shift.
	always_comb begin
		pos_c = '0;
		for (int k = 0; k < PW; k++) begin
			if (mx_s5[k]) begin
				pos_c = SW'(k);
			end
		end
		rs_c = (pos_c >= SW'(NB)) ? pos_c - SW'(NB - 1) : '0;
		ls_c = (pos_c < SW'(NB - 1)) ? SW'(NB - 1) - pos_c : '0;
		for (int k = 0; k < 4; k++) begin
			ext_c[k] = (NW'(mg_s6[k]) >> rs_s6) << ls_s6;
		end
	end

	// Front control stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
			side_s2 <= '0;
			side_s3 <= '0;
			side_s4 <= '0;
			side_s5 <= '0;
			side_s6 <= '0;
			side_s7 <= '0;
			side_s8 <= '0;
			side_s9 <= '0;
		end else if (en) begin
			side_s1 <= '{vld: in_valid, obtuse: 1'b0, degen: 1'b0};
			side_s2 <= '{vld: side_s1.vld, obtuse: 1'b0,
				degen: ({ux_s1, uy_s1, uz_s1} == '0) || ({vx_s1, vy_s1, vz_s1} == '0)};
			side_s3 <= side_s2;
			side_s4 <= '{vld: side_s3.vld, obtuse: dot_s3[PW-1], degen: side_s3.degen};
			side_s5 <= side_s4;
			side_s6 <= side_s5;
			side_s7 <= side_s6;
			side_s8 <= side_s7;
			side_s9 <= side_s8;
		end
	end

	// Front datapath: differences, products, sums, normalization, squares.
	always_ff @(posedge clk) begin
		if (en) begin
			ux_s1 <= {middle_x[COORD_BITS-1], middle_x} - {first_x[COORD_BITS-1], first_x};
			uy_s1 <= {middle_y[COORD_BITS-1], middle_y} - {first_y[COORD_BITS-1], first_y};
			uz_s1 <= {middle_z[COORD_BITS-1], middle_z} - {first_z[COORD_BITS-1], first_z};
			vx_s1 <= {last_x[COORD_BITS-1], last_x} - {middle_x[COORD_BITS-1], middle_x};
			vy_s1 <= {last_y[COORD_BITS-1], last_y} - {middle_y[COORD_BITS-1], middle_y};
			vz_s1 <= {last_z[COORD_BITS-1], last_z} - {middle_z[COORD_BITS-1], middle_z};
			pdx_s2 <= ux_s1 * vx_s1;
			pdy_s2 <= uy_s1 * vy_s1;
			pdz_s2 <= uz_s1 * vz_s1;
			pc1_s2 <= uy_s1 * vz_s1;
			pc2_s2 <= uz_s1 * vy_s1;
			pc3_s2 <= uz_s1 * vx_s1;
			pc4_s2 <= ux_s1 * vz_s1;
			pc5_s2 <= ux_s1 * vy_s1;
			pc6_s2 <= uy_s1 * vx_s1;
			dot_s3 <= PW'(pdx_s2) + PW'(pdy_s2) + PW'(pdz_s2);
			wx_s3  <= PW'(pc1_s2) - PW'(pc2_s2);
			wy_s3  <= PW'(pc3_s2) - PW'(pc4_s2);
			wz_s3  <= PW'(pc5_s2) - PW'(pc6_s2);
			mg_s4  <= mg_c;
			mg_s5  <= mg_s4;
			mx_s5  <= mx_c;
			mg_s6  <= mg_s5;
			rs_s6  <= rs_c;
			ls_s6  <= ls_c;
			for (int k = 0; k < 4; k++) begin
				nm_s7[k] <= ext_c[k][NB-1:0];
			end
			md_s8  <= nm_s7[0];
			sq1_s8 <= nm_s7[1] * nm_s7[1];
			sq2_s8 <= nm_s7[2] * nm_s7[2];
			sq3_s8 <= nm_s7[3] * nm_s7[3];
			md_s9  <= md_s8;
			ysq_s9 <= RW'(sq1_s8) + RW'(sq2_s8) + RW'(sq3_s8);
		end
	end

	// Square root chain: one root digit per cell.
	assign sq_side[0] = side_s9;
	assign sq_n[0]    = ysq_s9;
	assign sq_res[0]  = '0;
	assign sq_x[0]    = md_s9;

	for (genvar g = 0; g < SQN; g++) begin : g_sqrt
		tvac_sqrt_cell #(.IDX(g)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.side_i (sq_side[g]),
			.n_i    (sq_n[g]),
			.res_i  (sq_res[g]),
			.x_i    (sq_x[g]),
			.side_o (sq_side[g+1]),
			.n_o    (sq_n[g+1]),
			.res_o  (sq_res[g+1]),
			.x_o    (sq_x[g+1])
		);
	end

	// Arctangent chain: one vectoring rotation per cell.
	assign cr_side[0] = sq_side[SQN];
	assign cr_x[0]    = XW'({1'b0, sq_x[SQN]});
	assign cr_y[0]    = XW'({1'b0, sq_res[SQN][SQN-1:0]});
	assign cr_z[0]    = '0;

	for (genvar g = 0; g < CRN; g++) begin : g_cordic
		tvac_cordic_cell #(.IDX(g)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.side_i (cr_side[g]),
			.x_i    (cr_x[g]),
			.y_i    (cr_y[g]),
			.z_i    (cr_z[g]),
			.side_o (cr_side[g+1]),
			.x_o    (cr_x[g+1]),
			.y_o    (cr_y[g+1]),
			.z_o    (cr_z[g+1])
		);
	end

	// Clamp to a right angle, fold obtuse angles and round to centidegrees.
	always_comb begin
		zc_c = cr_z[CRN];
		if (zc_c < 0) begin
			zc_c = '0;
		end else if (zc_c > tvac_pkg::Z_RIGHT) begin
			zc_c = tvac_pkg::Z_RIGHT;
		end
		ang_c = cr_side[CRN].obtuse ? tvac_pkg::Z_STRAIGHT - zc_c : zc_c;
		rnd_c = ang_c + tvac_pkg::Z_HALF_LSB;
	end

	// Output register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= cr_side[CRN].vld;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (en) begin
			degenerate_q <= cr_side[CRN].degen;
			angle_q      <= cr_side[CRN].degen ? '0 :
				rnd_c[tvac_pkg::UNIT_SHIFT+AW-1:tvac_pkg::UNIT_SHIFT];
		end
	end

	assign out_valid      = out_valid_q;
	assign degenerate     = degenerate_q;
	assign angle_centideg = angle_q;

	// A degenerate result always carries a zero angle.
	`TVAC_ASSERT_NOW(a_degen_zero, out_valid_q && degenerate_q, angle_q == '0)
	// The angle never exceeds a straight angle.
	`TVAC_ASSERT_NOW(a_angle_range, out_valid_q, angle_q <= AW'(18000))
	// While the output is held, the last rotation cell holds its transaction.
	`TVAC_ASSERT_NEXT(a_chain_holds, out_valid_q && out_stall, $stable(cr_side[CRN]))

endmodule
`default_nettype wire
